FILE: src/anbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// anbs_pkg: shared types and constants of the Annex-B NAL splitter
// Field widths, register indexes, command codes between front and back,
// and the status group of the descriptor queue.
// ----------------------------------------------------------------------------
package anbs_pkg;

	localparam int OFFSET_BITS_DEF = 24;
	localparam int FIELD_BITS      = 24;
	localparam int TYPE_BITS       = 5;
	localparam int BYTE_BITS       = 8;
	localparam int OUT_TDATA_BITS  = 56;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 8;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_SHORTCUT_EN  = 2'd0,
		CFG_FINAL_FIRST  = 2'd1,
		CFG_FINAL_SECOND = 2'd2
	} cfg_index_t;

	localparam logic [BYTE_BITS-1:0] FINAL_FIRST_RST  = 8'h41;
	localparam logic [BYTE_BITS-1:0] FINAL_SECOND_RST = 8'h65;
	localparam logic [23:0]          START_CODE       = 24'h000001;
	localparam logic [BYTE_BITS-1:0] START_CODE_LAST  = 8'h01;

	typedef struct packed {
		logic                 shortcut_en;
		logic [BYTE_BITS-1:0] final_first;
		logic [BYTE_BITS-1:0] final_second;
	} cfg_t;

	typedef enum logic [1:0] {
		CMD_CLOSE      = 2'd0,
		CMD_CLOSE_TRIM = 2'd1,
		CMD_RUN_END    = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t            kind;
		logic [TYPE_BITS-1:0] nal_type;
		logic                 buffer_end;
		logic                 overflow;
	} cmd_info_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = 2;
	localparam int QCNT_BITS   = 3;

	typedef struct packed {
		logic                 full;
		logic                 empty;
		logic [QCNT_BITS-1:0] count;
	} queue_status_t;

endpackage
`default_nettype wire

FILE: src/annexb_nal_splitter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// annexb_nal_splitter_core: H.264 Annex-B NAL unit splitter
// Splits a byte stream at 00 00 01 start codes and reports one descriptor
// per NAL unit.
// ----------------------------------------------------------------------------
// Input stream: one buffer byte per transfer in s_axis_tdata[7:0]; s_axis_tlast
// marks the last byte of a buffer. All scan state clears after that byte.
// Output stream: one descriptor per NAL unit. m_axis_tdata holds offset,
// length and type; m_axis_tlast is set when the unit closed on the buffer's
// last byte; m_axis_tuser flags a saturated byte position in the buffer.
// Configuration: cfg_wr_en with cfg_index and cfg_data writes one register
// (0 shortcut enable, 1 first final header, 2 second final header); write
// only while the block is idle.
// Throughput is one byte per cycle while the descriptor queue is not full. A
// descriptor passes from the byte that closes its unit into the four-entry
// descriptor queue and then into the output register.
// When the receiver stalls, descriptors collect in the queue; s_axis_tready
// drops only when the queue is full. Reset clears the scan state, empties
// the queue and loads the register defaults.
// ----------------------------------------------------------------------------
module annexb_nal_splitter_core #(
	parameter int OFFSET_BITS = anbs_pkg::OFFSET_BITS_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    cfg_wr_en,
	input  wire  [anbs_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  wire  [anbs_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	input  wire                                    s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire  [anbs_pkg::BYTE_BITS-1:0]         s_axis_tdata,  // [7:0] data_byte
	input  wire                                    s_axis_tlast,
	output logic                                   m_axis_tvalid,
	input  wire                                    m_axis_tready,
	// [23:0] nal_offset, [47:24] nal_length, [52:48] nal_type, [55:53] zero
	output logic [anbs_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata,
	output logic                                   m_axis_tlast,
	output logic                                   m_axis_tuser   // [0] offset_overflow
);
	import anbs_pkg::*;

	cfg_t                   cfg_q;
	queue_status_t          q_status;
	logic                   push;
	logic [OFFSET_BITS-1:0] push_pos;
	logic [OFFSET_BITS-1:0] push_start;
	cmd_info_t              push_info;
	logic                   pop;
	logic [OFFSET_BITS-1:0] head_pos;
	logic [OFFSET_BITS-1:0] head_start;
	cmd_info_t              head_info;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shortcut_en  <= 1'b0;
			cfg_q.final_first  <= FINAL_FIRST_RST;
			cfg_q.final_second <= FINAL_SECOND_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_SHORTCUT_EN:  cfg_q.shortcut_en  <= cfg_data[0];
				CFG_FINAL_FIRST:  cfg_q.final_first  <= cfg_data;
				CFG_FINAL_SECOND: cfg_q.final_second <= cfg_data;
				default: ;
			endcase
		end
	end

	anbs_front #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.q_status  (q_status),
		.push      (push),
		.push_pos  (push_pos),
		.push_start(push_start),
		.push_info (push_info)
	);

	anbs_queue #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_pos  (push_pos),
		.push_start(push_start),
		.push_info (push_info),
		.pop       (pop),
		.head_pos  (head_pos),
		.head_start(head_start),
		.head_info (head_info),
		.status    (q_status)
	);

	anbs_back #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.head_pos  (head_pos),
		.head_start(head_start),
		.head_info (head_info),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_user  (m_axis_tuser)
	);

`ifndef SYNTH
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.count <= QCNT_BITS'(QUEUE_DEPTH))
		else $error("descriptor queue count out of range");

	a_full_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.full |-> !s_axis_tready)
		else $error("input accepted while descriptor queue full");

	a_pop_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> m_axis_tvalid)
		else $error("popped descriptor did not reach the output");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop && !q_status.full |=> !q_status.empty)
		else $error("pushed descriptor lost");
`endif

endmodule
`default_nettype wire

FILE: src/anbs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// anbs_front: byte scanner
// Tracks start codes, the open unit and the byte position per buffer, and
// pushes one command per finished unit into the descriptor queue.
// ----------------------------------------------------------------------------
module anbs_front #(
	parameter int OFFSET_BITS = anbs_pkg::OFFSET_BITS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  anbs_pkg::cfg_t                    cfg,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire  [anbs_pkg::BYTE_BITS-1:0]    in_byte,
	input  wire                               in_last,
	input  anbs_pkg::queue_status_t           q_status,
	output logic                              push,
	output logic [OFFSET_BITS-1:0]            push_pos,
	output logic [OFFSET_BITS-1:0]            push_start,
	output anbs_pkg::cmd_info_t               push_info
);
	import anbs_pkg::*;

	logic [23:0]            recent_q;
	logic [1:0]             hist_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic [OFFSET_BITS-1:0] start_q;
	logic                   inside_q;
	logic [TYPE_BITS-1:0]   kind_q;
	logic                   final_q;
	logic                   sat_q;

	logic                   take;
	logic                   at_top;
	logic                   sat_n;
	logic [OFFSET_BITS-1:0] span;
	logic                   close_hit;
	logic                   run_end;
	logic                   hdr_hit;
	logic                   is_final;

	assign in_ready  = !q_status.full;
	assign take      = in_valid && in_ready;
	assign at_top    = &pos_q;
	assign sat_n     = sat_q || at_top;
	assign span      = pos_q - start_q;
	assign close_hit = inside_q && !final_q && (span >= OFFSET_BITS'(3))
		&& (recent_q[15:0] == 16'h0000) && (in_byte == START_CODE_LAST);
	assign run_end   = inside_q && !close_hit && in_last;
	assign hdr_hit   = !inside_q && !final_q && (hist_q == 2'd3) && (recent_q == START_CODE);
	assign is_final  = cfg.shortcut_en
		&& ((in_byte == cfg.final_first) || (in_byte == cfg.final_second));

	always_comb begin
		push                 = take && (close_hit || run_end || (hdr_hit && in_last));
		push_pos             = pos_q;
		push_start           = hdr_hit ? pos_q : start_q;
		push_info.nal_type   = hdr_hit ? in_byte[TYPE_BITS-1:0] : kind_q;
		push_info.buffer_end = in_last;
		push_info.overflow   = sat_n;
		if (close_hit) begin
			push_info.kind = (recent_q[23:16] == 8'h00) ? CMD_CLOSE_TRIM : CMD_CLOSE;
		end else begin
			push_info.kind = CMD_RUN_END;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= '0;
			hist_q   <= '0;
			pos_q    <= '0;
			start_q  <= '0;
			inside_q <= 1'b0;
			kind_q   <= '0;
			final_q  <= 1'b0;
			sat_q    <= 1'b0;
		end else if (take) begin
			if (in_last) begin
				recent_q <= '0;
				hist_q   <= '0;
				pos_q    <= '0;
				start_q  <= '0;
				inside_q <= 1'b0;
				kind_q   <= '0;
				final_q  <= 1'b0;
				sat_q    <= 1'b0;
			end else begin
				recent_q <= {recent_q[15:0], in_byte};
				if (hist_q != 2'd3) begin
					hist_q <= hist_q + 2'd1;
				end
				if (!at_top) begin
					pos_q <= pos_q + OFFSET_BITS'(1);
				end
				sat_q <= sat_n;
				if (close_hit) begin
					inside_q <= 1'b0;
				end
				if (hdr_hit) begin
					start_q  <= pos_q;
					kind_q   <= in_byte[TYPE_BITS-1:0];
					inside_q <= 1'b1;
					final_q  <= is_final;
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/anbs_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// anbs_queue: descriptor queue
// Short first-in first-out store of unit commands between scanner and
// descriptor builder.
// ----------------------------------------------------------------------------
module anbs_queue #(
	parameter int OFFSET_BITS = anbs_pkg::OFFSET_BITS_DEF
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       push,
	input  wire  [OFFSET_BITS-1:0]    push_pos,
	input  wire  [OFFSET_BITS-1:0]    push_start,
	input  anbs_pkg::cmd_info_t       push_info,
	input  wire                       pop,
	output logic [OFFSET_BITS-1:0]    head_pos,
	output logic [OFFSET_BITS-1:0]    head_start,
	output anbs_pkg::cmd_info_t       head_info,
	output anbs_pkg::queue_status_t   status
);
	import anbs_pkg::*;

	logic [OFFSET_BITS-1:0] pos_mem   [QUEUE_DEPTH];
	logic [OFFSET_BITS-1:0] start_mem [QUEUE_DEPTH];
	cmd_info_t              info_mem  [QUEUE_DEPTH];

	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic                 do_push;
	logic                 do_pop;

	assign status.full  = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign status.count = count_q;
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;

	assign head_pos   = pos_mem[rd_ptr_q];
	assign head_start = start_mem[rd_ptr_q];
	assign head_info  = info_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			pos_mem[wr_ptr_q]   <= push_pos;
			start_mem[wr_ptr_q] <= push_start;
			info_mem[wr_ptr_q]  <= push_info;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_BITS'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_BITS'(1);
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/anbs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// anbs_back: descriptor builder
// Turns a queued command into offset, length and type, and holds the result
// in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module anbs_back #(
	parameter int OFFSET_BITS = anbs_pkg::OFFSET_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  anbs_pkg::queue_status_t              q_status,
	input  wire  [OFFSET_BITS-1:0]               head_pos,
	input  wire  [OFFSET_BITS-1:0]               head_start,
	input  anbs_pkg::cmd_info_t                  head_info,
	output logic                                 pop,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic [anbs_pkg::OUT_TDATA_BITS-1:0]  out_data,
	output logic                                 out_last,
	output logic                                 out_user
);
	import anbs_pkg::*;

	localparam int WIDE_BITS = (OFFSET_BITS > FIELD_BITS) ? OFFSET_BITS : FIELD_BITS;

	logic [OFFSET_BITS-1:0] span;
	logic [OFFSET_BITS-1:0] len;
	logic [WIDE_BITS-1:0]   len_w;
	logic [WIDE_BITS-1:0]   off_w;

	logic                      valid_q;
	logic [OUT_TDATA_BITS-1:0] data_q;
	logic                      last_q;
	logic                      user_q;

	assign span = head_pos - head_start;

	always_comb begin
		case (head_info.kind)
			CMD_CLOSE:      len = span - OFFSET_BITS'(2);
			CMD_CLOSE_TRIM: len = span - OFFSET_BITS'(3);
			CMD_RUN_END:    len = (&span) ? span : span + OFFSET_BITS'(1);
			default:        len = span + OFFSET_BITS'(1);
		endcase
	end

	assign len_w = WIDE_BITS'(len);
	assign off_w = WIDE_BITS'(head_start);
	assign pop   = !q_status.empty && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= {3'b000, head_info.nal_type,
				len_w[FIELD_BITS-1:0], off_w[FIELD_BITS-1:0]};
			last_q <= head_info.buffer_end;
			user_q <= head_info.overflow;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_last  = last_q;
	assign out_user  = user_q;

endmodule
`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for annexb_nal_splitter_core
// Streams Annex-B buffers byte by byte, forecasts every NAL descriptor with a
// cycle-free scanner model and checks each descriptor transfer in order.
// ----------------------------------------------------------------------------
module testbench;
	import anbs_pkg::*;

	localparam int OFS_W = OFFSET_BITS_DEF;
	localparam bit [63:0] POS_TOP = (64'd1 << OFS_W) - 64'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 8;

	typedef logic [BYTE_BITS-1:0] byte_q_t[$];

	typedef struct {
		logic [FIELD_BITS-1:0] ofs;
		logic [FIELD_BITS-1:0] len;
		logic [TYPE_BITS-1:0]  kind;
		logic                  at_end;
		logic                  sat;
	} nal_desc_t;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_wr_en;
	logic [CFG_INDEX_BITS-1:0]   cfg_index;
	logic [CFG_DATA_BITS-1:0]    cfg_data;
	logic                        s_tvalid;
	logic                        s_tready;
	logic [BYTE_BITS-1:0]        s_tdata;
	logic                        s_tlast;
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	logic [OUT_TDATA_BITS-1:0]   m_tdata;
	logic                        m_tlast;
	logic                        m_tuser;

	int src_idle = 33;
	int snk_idle = 45;
	int error_count = 0;

	nal_desc_t pending_descs[$];
	nal_desc_t seen_desc;

	logic [23:0]          sc_recent;
	logic [1:0]           sc_count;
	bit [63:0]            sc_pos;
	bit [63:0]            sc_start;
	logic                 sc_open;
	logic [TYPE_BITS-1:0] sc_kind;
	logic                 sc_final;
	logic                 sc_sat;

	logic                 cfg_shortcut;
	logic [BYTE_BITS-1:0] cfg_first;
	logic [BYTE_BITS-1:0] cfg_second;

	annexb_nal_splitter_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tlast  (s_tlast),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tlast  (m_tlast),
		.m_axis_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic clear_scanner();
		sc_recent = '0;
		sc_count  = '0;
		sc_pos    = '0;
		sc_start  = '0;
		sc_open   = 1'b0;
		sc_kind   = '0;
		sc_final  = 1'b0;
		sc_sat    = 1'b0;
	endtask

	task automatic advance_scanner(input logic [BYTE_BITS-1:0] b, input logic last);
		bit [63:0] pos;
		bit [63:0] stop;
		bit [63:0] len;
		bit        hit;
		nal_desc_t d;
		pos = sc_pos & POS_TOP;
		hit = 1'b0;
		len = '0;
		if (pos == POS_TOP) sc_sat = 1'b1;
		else sc_pos = pos + 64'd1;
		if (sc_open) begin
			if (!sc_final && pos >= sc_start + 64'd3 && sc_recent[15:0] == 16'h0000 &&
			    b == START_CODE_LAST) begin
				stop = pos - 64'd2;
				if (sc_recent[23:16] == 8'h00) stop = stop - 64'd1;
				len = stop - sc_start;
				hit = 1'b1;
				sc_open = 1'b0;
			end else if (last) begin
				len = pos + 64'd1 - sc_start;
				if (len > POS_TOP) len = POS_TOP;
				hit = 1'b1;
			end
		end else if (!sc_final && sc_count == 2'd3 && sc_recent == START_CODE) begin
			sc_start = pos;
			sc_kind  = b[TYPE_BITS-1:0];
			sc_open  = 1'b1;
			if (cfg_shortcut && (b == cfg_first || b == cfg_second)) sc_final = 1'b1;
			if (last) begin
				len = 64'd1;
				hit = 1'b1;
			end
		end
		if (hit) begin
			d.ofs    = sc_start[FIELD_BITS-1:0];
			d.len    = len[FIELD_BITS-1:0];
			d.kind   = sc_kind;
			d.at_end = last;
			d.sat    = sc_sat;
			pending_descs = {pending_descs, d};
		end
		sc_recent = {sc_recent[15:0], b};
		if (sc_count != 2'd3) sc_count = sc_count + 2'd1;
		if (last) clear_scanner();
	endtask

	task automatic report_mismatch(input string what, input longint unsigned got,
	                               input longint unsigned want);
		$display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
		error_count++;
	endtask

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= snk_idle);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (pending_descs.size() == 0) begin
				report_mismatch("unexpected descriptor", m_tdata, 0);
			end else begin
				seen_desc = pending_descs.pop_front();
				if (m_tdata[23:0] !== seen_desc.ofs)
					report_mismatch("nal_offset", m_tdata[23:0], seen_desc.ofs);
				if (m_tdata[47:24] !== seen_desc.len)
					report_mismatch("nal_length", m_tdata[47:24], seen_desc.len);
				if (m_tdata[52:48] !== seen_desc.kind)
					report_mismatch("nal_type", m_tdata[52:48], seen_desc.kind);
				if (m_tlast !== seen_desc.at_end)
					report_mismatch("buffer_end", m_tlast, seen_desc.at_end);
				if (m_tuser !== seen_desc.sat)
					report_mismatch("offset_overflow", m_tuser, seen_desc.sat);
			end
		end
	end

	// Called and returns on a falling edge; holds tvalid across back-to-back bytes.
	task automatic send_byte(input logic [BYTE_BITS-1:0] b, input logic last);
		while ($urandom_range(0, 99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		advance_scanner(b, last);
		@(negedge clk);
	endtask

	task automatic send_buffer(input byte_q_t q);
		for (int i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_descs.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
	                         input logic [CFG_DATA_BITS-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_SHORTCUT_EN:  cfg_shortcut = v[0];
			CFG_FINAL_FIRST:  cfg_first    = v;
			CFG_FINAL_SECOND: cfg_second   = v;
			default: ;
		endcase
		@(negedge clk);
	endtask

	function automatic logic [BYTE_BITS-1:0] noise_byte();
		case ($urandom_range(0, 3))
			0, 1:    return 8'h00;
			2:       return START_CODE_LAST;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic byte_q_t build_buffer();
		byte_q_t              q;
		int                   units;
		int                   cut;
		logic [BYTE_BITS-1:0] hdr;
		q = {};
		if ($urandom_range(0, 9) >= 8) begin
			repeat ($urandom_range(1, 12)) q = {q, noise_byte()};
			return q;
		end
		repeat ($urandom_range(0, 2)) q = {q, noise_byte()};
		units = $urandom_range(1, 4);
		for (int u = 0; u < units; u++) begin
			if ($urandom_range(0, 1)) q = {q, 8'h00};
			q = {q, 8'h00};
			q = {q, 8'h00};
			q = {q, START_CODE_LAST};
			cut = (u == units - 1) ? $urandom_range(0, 7) : 7;
			if (cut == 0) break;
			case ($urandom_range(0, 7))
				0, 1:    hdr = cfg_first;
				2:       hdr = cfg_second;
				3:       hdr = 8'h00;
				default: hdr = 8'($urandom_range(0, 255));
			endcase
			q = {q, hdr};
			if (cut == 1) break;
			repeat ($urandom_range(0, 8))
				q = {q, (($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255)))};
			if ($urandom_range(0, 3) == 0) q = {q, 8'h00};
		end
		return q;
	endfunction

	task automatic test_buffer_edges();
		byte_q_t q;
		q = '{8'h00, 8'h00, 8'h01};
		send_buffer(q);
		q = '{8'h00, 8'h00, 8'h01, 8'h67};
		send_buffer(q);
		q = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF};
		send_buffer(q);
		wait_drained();
	endtask

	task automatic test_final_shortcut();
		byte_q_t q;
		write_reg(CFG_SHORTCUT_EN, 8'h01);
		write_reg(CFG_FINAL_FIRST, 8'h00);
		write_reg(CFG_FINAL_SECOND, 8'hFF);
		write_reg(CFG_UNUSED, 8'h5A);
		q = '{8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h09, 8'hAA};
		send_buffer(q);
		wait_drained();
	endtask

	task automatic test_random_buffers(input int n_bytes, input int src_pct, input int snk_pct,
	                                   input logic [CFG_DATA_BITS-1:0] en,
	                                   input logic [CFG_DATA_BITS-1:0] first,
	                                   input logic [CFG_DATA_BITS-1:0] second);
		byte_q_t q;
		int      sent;
		write_reg(CFG_SHORTCUT_EN, en);
		write_reg(CFG_FINAL_FIRST, first);
		write_reg(CFG_FINAL_SECOND, second);
		src_idle = src_pct;
		snk_idle = snk_pct;
		sent = 0;
		while (sent < n_bytes) begin
			q = build_buffer();
			send_buffer(q);
			sent += q.size();
		end
		wait_drained();
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_SHORTCUT_EN;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		clear_scanner();
		cfg_shortcut = 1'b0;
		cfg_first    = FINAL_FIRST_RST;
		cfg_second   = FINAL_SECOND_RST;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_buffer_edges();
		test_final_shortcut();
		test_random_buffers(270, 33, 45, 8'h01, FINAL_FIRST_RST, FINAL_SECOND_RST);
		test_random_buffers(270, 45, 33, 8'hFE, 8'h00, 8'hFF);
		test_random_buffers(270, 0, 0, 8'h03, 8'($urandom_range(0, 255)),
		                    8'($urandom_range(0, 255)));

		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
